// File: hw/rtl/etg_pkg.sv
package etg_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int TIME_WIDTH = 24;

   localparam int OP_W    = 2;
   localparam int POS_W   = 32;
   localparam int DUR_W   = 24;
   localparam int CURVE_W = 3;

   // span of two positions, and the shared multiplier operands
   localparam int SPAN_W  = POS_W + 1;
   localparam int FACT_W  = FRAC_BITS + 1;
   localparam int MUL_B_W = FACT_W + 1;
   localparam int PROD_W  = SPAN_W + MUL_B_W;
   localparam int CNT_W   = $clog2(FRAC_BITS);

   localparam logic [OP_W-1:0] OP_SET   = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

   localparam logic [CURVE_W-1:0] CURVE_LINEAR    = 3'd0;
   localparam logic [CURVE_W-1:0] CURVE_EASE_IN   = 3'd1;
   localparam logic [CURVE_W-1:0] CURVE_EASE_OUT  = 3'd2;
   localparam logic [CURVE_W-1:0] CURVE_IN_OUT    = 3'd3;
   localparam logic [CURVE_W-1:0] CURVE_SUPER_OUT = 3'd4;

   localparam logic [FACT_W-1:0]    ONE_Q  = FACT_W'(1) << FRAC_BITS;
   localparam logic [FRAC_BITS-1:0] HALF_Q = FRAC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [PROD_W-1:0]    ROUND_Q = PROD_W'(1) << (FRAC_BITS - 1);

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   localparam int CLAMP_W = ((DUR_W > TIME_WIDTH) ? DUR_W : TIME_WIDTH) + 1;
   localparam logic [CLAMP_W-1:0] TIME_MAX_W =
      {{(CLAMP_W - TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SQUARE,
      ST_SQUARE2,
      ST_TIMES_P,
      ST_FACTOR,
      ST_SCALE,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   function automatic logic [TIME_WIDTH-1:0] clamp_time(input logic [DUR_W-1:0] v);
      logic [CLAMP_W-1:0] wide;
      wide = CLAMP_W'(v);
      if (wide > TIME_MAX_W) return TIME_MAX;
      return wide[TIME_WIDTH-1:0];
   endfunction

endpackage

// File: hw/rtl/easing_tween_generator.sv
// set and start items: result valid 1 cycle after the item is accepted
// tick items: 1 cycle when the target is reached, else 21 to 23 cycles,
// set by the 16-step restoring divider plus up to 4 passes through the one multiplier
// one item in flight at a time; a new item is taken once the result has been taken
// synchronous active-high reset clears position, target, curve and tick counters to zero
module easing_tween_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [etg_pkg::OP_W-1:0]            req_operation,
   input  logic signed [etg_pkg::POS_W-1:0]    req_target_value,
   input  logic [etg_pkg::DUR_W-1:0]           req_duration_ticks,
   input  logic [etg_pkg::CURVE_W-1:0]         req_curve,
   input  logic [etg_pkg::DUR_W-1:0]           req_time_step,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [etg_pkg::POS_W-1:0]    rsp_position,
   output logic                                rsp_finished
);
   import etg_pkg::*;

   state_type state_ff, state_in;

   logic signed [POS_W-1:0]  start_ff, start_in;
   logic signed [POS_W-1:0]  end_ff, end_in;
   logic signed [POS_W-1:0]  cur_ff, cur_in;
   logic [CURVE_W-1:0]       curve_ff, curve_in;
   logic [TIME_WIDTH-1:0]    elapsed_ff, elapsed_in;
   logic [TIME_WIDTH-1:0]    total_ff, total_in;
   logic [TIME_WIDTH:0]      rem_ff, rem_in;
   logic [FRAC_BITS-1:0]     p_ff, p_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [FACT_W-1:0]        f_ff, f_in;
   logic signed [SPAN_W-1:0] span_ff, span_in;
   logic signed [SPAN_W-1:0] base_ff, base_in;
   logic signed [SPAN_W-1:0] mul_ff, mul_in;

   logic [TIME_WIDTH:0]      tick_sum;
   logic [TIME_WIDTH-1:0]    tick_elapsed;
   logic [TIME_WIDTH:0]      rem_dbl;
   logic                     quot_bit;
   logic [FACT_W-1:0]        p_wide;
   logic [FACT_W-1:0]        q_val;
   logic [FACT_W-1:0]        t_val;
   logic [FACT_W-1:0]        t_dbl;
   logic                     late_half;
   logic signed [SPAN_W-1:0] start_w, end_w, mid;

   logic signed [SPAN_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  product;
   logic signed [PROD_W-1:0]  rounded;

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESPOND);
   assign rsp_position = cur_ff;
   assign rsp_finished = (cur_ff == end_ff);

   assign tick_sum     = {1'b0, elapsed_ff} + {1'b0, clamp_time(req_time_step)};
   assign tick_elapsed = tick_sum[TIME_WIDTH] ? TIME_MAX : tick_sum[TIME_WIDTH-1:0];

   assign rem_dbl  = {rem_ff[TIME_WIDTH-1:0], 1'b0};
   assign quot_bit = (rem_dbl >= {1'b0, total_ff});

   assign p_wide    = {1'b0, p_ff};
   assign q_val     = ONE_Q - p_wide;
   assign t_val     = mul_ff[FACT_W-1:0];
   assign t_dbl     = {t_val[FACT_W-2:0], 1'b0};
   assign late_half = (p_ff > HALF_Q);

   assign start_w = SPAN_W'(start_ff);
   assign end_w   = SPAN_W'(end_ff);
   assign mid     = (start_w + end_w) >>> 1;

   // shared multiplier, rounded half up back to the fraction grid
   assign product = mul_a * mul_b;
   assign rounded = (product + $signed(ROUND_Q)) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         end_ff     <= '0;
         cur_ff     <= '0;
         curve_ff   <= CURVE_LINEAR;
         elapsed_ff <= '0;
         total_ff   <= '0;
      end else begin
         start_ff   <= start_in;
         end_ff     <= end_in;
         cur_ff     <= cur_in;
         curve_ff   <= curve_in;
         elapsed_ff <= elapsed_in;
         total_ff   <= total_in;
      end
      rem_ff  <= rem_in;
      p_ff    <= p_in;
      cnt_ff  <= cnt_in;
      f_ff    <= f_in;
      span_ff <= span_in;
      base_ff <= base_in;
      mul_ff  <= mul_in;
   end

   always_comb begin
      state_in   = state_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      cur_in     = cur_ff;
      curve_in   = curve_ff;
      elapsed_in = elapsed_ff;
      total_in   = total_ff;
      rem_in     = rem_ff;
      p_in       = p_ff;
      cnt_in     = cnt_ff;
      f_in       = f_ff;
      span_in    = span_ff;
      base_in    = base_ff;
      mul_in     = mul_ff;
      mul_a      = SPAN_W'($signed({1'b0, p_wide}));
      mul_b      = $signed({1'b0, p_wide});

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RESPOND;
               case (req_operation)
                  OP_SET: begin
                     start_in   = req_target_value;
                     end_in     = req_target_value;
                     cur_in     = req_target_value;
                     curve_in   = CURVE_LINEAR;
                     elapsed_in = '0;
                     total_in   = '0;
                  end
                  OP_START: begin
                     curve_in   = req_curve;
                     start_in   = cur_ff;
                     end_in     = req_target_value;
                     elapsed_in = '0;
                     total_in   = clamp_time(req_duration_ticks);
                  end
                  OP_TICK: begin
                     elapsed_in = tick_elapsed;
                     if (tick_elapsed >= total_ff) begin
                        cur_in = end_ff;
                     end else begin
                        rem_in   = {1'b0, tick_elapsed};
                        cnt_in   = CNT_W'(FRAC_BITS - 1);
                        state_in = ST_DIVIDE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // one quotient bit of elapsed / total per cycle
         ST_DIVIDE: begin
            rem_in = quot_bit ? (rem_dbl - {1'b0, total_ff}) : rem_dbl;
            p_in   = {p_ff[FRAC_BITS-2:0], quot_bit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (curve_ff == CURVE_EASE_OUT || (curve_ff == CURVE_IN_OUT && late_half)) begin
               mul_a = SPAN_W'($signed({1'b0, q_val}));
               mul_b = $signed({1'b0, q_val});
            end
            mul_in = rounded[SPAN_W-1:0];
            if (curve_ff == CURVE_EASE_OUT || (curve_ff == CURVE_SUPER_OUT && late_half))
               state_in = ST_SQUARE2;
            else
               state_in = ST_FACTOR;
         end
         ST_SQUARE2: begin
            mul_a  = SPAN_W'($signed({1'b0, t_val}));
            mul_b  = $signed({1'b0, t_val});
            mul_in = rounded[SPAN_W-1:0];
            state_in = (curve_ff == CURVE_SUPER_OUT) ? ST_TIMES_P : ST_FACTOR;
         end
         ST_TIMES_P: begin
            mul_a    = SPAN_W'($signed({1'b0, t_val}));
            mul_in   = rounded[SPAN_W-1:0];
            state_in = ST_FACTOR;
         end
         ST_FACTOR: begin
            base_in = start_w;
            span_in = end_w - start_w;
            case (curve_ff)
               CURVE_EASE_IN:  f_in = t_val;
               CURVE_EASE_OUT: f_in = ONE_Q - t_val;
               CURVE_IN_OUT:   f_in = late_half ? (ONE_Q - t_dbl) : t_dbl;
               CURVE_SUPER_OUT: begin
                  if (late_half) begin
                     // second half restarts from the midpoint
                     f_in    = t_val;
                     base_in = mid;
                     span_in = end_w - mid;
                  end else begin
                     f_in = p_wide;
                  end
               end
               default: f_in = p_wide;
            endcase
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            mul_a    = span_ff;
            mul_b    = $signed({1'b0, f_ff});
            mul_in   = rounded[SPAN_W-1:0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cur_in   = POS_W'(base_ff + mul_ff);
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hw/rtl/etg_checker.sv
module etg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [etg_pkg::OP_W-1:0]            req_operation,
   input logic signed [etg_pkg::POS_W-1:0]    req_target_value,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [etg_pkg::POS_W-1:0]    rsp_position,
   input logic                                rsp_finished
);
   import etg_pkg::*;

   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // a waiting result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position) && $stable(rsp_finished))
      else $error("stalled result changed");

   // only one item in flight
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is pending");

   // a set item lands on its value at once and reports finished
   assert property (@(posedge clock) disable iff (reset)
      req_take && req_operation == OP_SET
      |=> rsp_valid && rsp_finished && rsp_position == $past(req_target_value))
      else $error("set item did not jump to its value");

   // a start item does not move the position
   assert property (@(posedge clock) disable iff (reset)
      req_take && req_operation == OP_START
      |=> rsp_valid && rsp_position == $past(rsp_position))
      else $error("start item moved the position");

   assert property (@(posedge clock) disable iff (reset)
      rsp_take |=> req_ready)
      else $error("block not ready after result taken");

endmodule

bind easing_tween_generator etg_checker u_etg_checker (.*);
